// ===== design/jkve_pkg.sv =====
// Shared types and constants for the JSON key/value extractor.
// Used by the front, queue and back modules; depends on nothing.
package jkve_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_LBRK   = 8'h5b;
    localparam logic [7:0] CH_RBRK   = 8'h5d;
    localparam logic [7:0] CH_LBRC   = 8'h7b;
    localparam logic [7:0] CH_RBRC   = 8'h7d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [2:0] K_STRING  = 3'd0;
    localparam logic [2:0] K_NUMBER  = 3'd1;
    localparam logic [2:0] K_BOOLEAN = 3'd2;
    localparam logic [2:0] K_NULL    = 3'd3;
    localparam logic [2:0] K_ARRAY   = 3'd4;
    localparam logic [2:0] K_OBJECT  = 3'd5;

    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_EMPTYKEY = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_BADVAL   = 3'd4;

    localparam logic [1:0] REG_KEY_LO = 2'd0;
    localparam logic [1:0] REG_KEY_HI = 2'd1;
    localparam logic [1:0] REG_LEN    = 2'd2;

    typedef struct packed {
        logic [7:0] cur;
        logic       cur_valid;
        logic       last;
        logic       short_doc;
    } jkve_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] value_type;
        logic       done_res;
        logic [2:0] status;
    } jkve_res_t;

endpackage

// ===== design/jkve_front.sv =====
// Front part: accepts document bytes, drops the first and last, holds one
// byte so the last inner byte is known. Depends on jkve_pkg.
module jkve_front
    import jkve_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output jkve_item_t item
);

    logic [7:0] held_byte_reg;
    logic       held_valid_reg;
    logic       first_reg;
    logic [1:0] doc_count_reg;
    logic [1:0] doc_count_next;

    always_comb
    begin
        doc_count_next = (doc_count_reg == 2'd3) ? 2'd3 : doc_count_reg + 2'd1;
        item.cur       = held_byte_reg;
        item.cur_valid = held_valid_reg && !first_reg;
        item.last      = in_last;
        item.short_doc = (doc_count_next != 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            first_reg      <= 1'b1;
            doc_count_reg  <= 2'd0;
            held_byte_reg  <= 8'd0;
        end
        else if (take)
        begin
            if (in_last)
            begin
                held_valid_reg <= 1'b0;
                first_reg      <= 1'b1;
                doc_count_reg  <= 2'd0;
            end
            else
            begin
                doc_count_reg <= doc_count_next;
                first_reg     <= 1'b0;
                if (!first_reg)
                begin
                    held_byte_reg  <= in_byte;
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/jkve_back.sv =====
// Back part: key search, value typing and value streaming on inner bytes.
// Depends on jkve_pkg.
module jkve_back
    import jkve_pkg::*;
#(
    parameter int MAX_KEY   = 16,
    parameter int MAX_DEPTH = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  jkve_item_t  item,
    input  logic [63:0] key_lo,
    input  logic [63:0] key_hi,
    input  logic [4:0]  key_len,
    output logic        res_valid,
    output jkve_res_t   res
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_KEYS, PH_COLON, PH_TYPE, PH_VALUE, PH_FOUND, PH_EMPTYKEY, PH_BAD
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [7:0]    prev_reg;
    logic          key_mode_reg, key_mode_next;
    logic          in_key_reg, in_key_next;
    logic [4:0]    key_pos_reg, key_pos_next;
    logic          key_eq_reg, key_eq_next;
    logic [2:0]    kind_reg, kind_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          inq_reg, inq_next;
    logic          emit;
    logic [7:0]    c;
    logic [7:0]    tbyte;
    logic [7:0]    opn, cls;
    logic          unesc_q;
    logic          do_val;
    logic [2:0]    st;

    always_comb
    begin
        c       = item.cur;
        tbyte   = key_pos_reg[3] ? key_hi[{key_pos_reg[2:0], 3'b000} +: 8]
                                 : key_lo[{key_pos_reg[2:0], 3'b000} +: 8];
        unesc_q = (c == CH_QUOTE) && (prev_reg != CH_BSLASH);
        phase_next    = phase_reg;
        key_mode_next = key_mode_reg;
        in_key_next   = in_key_reg;
        key_pos_next  = key_pos_reg;
        key_eq_next   = key_eq_reg;
        kind_next     = kind_reg;
        depth_next    = depth_reg;
        inq_next      = inq_reg;
        emit          = 1'b0;
        do_val        = 1'b0;
        opn = (kind_reg == K_ARRAY) ? CH_LBRK : CH_LBRC;
        cls = (kind_reg == K_ARRAY) ? CH_RBRK : CH_RBRC;
        if (item.cur_valid)
        begin
            unique case (phase_reg)
                PH_KEYS:
                begin
                    if (c == CH_QUOTE && key_mode_reg && !(c == CH_COLON))
                    begin
                        if (!in_key_reg)
                        begin
                            in_key_next  = 1'b1;
                            key_pos_next = 5'd0;
                            key_eq_next  = 1'b1;
                        end
                        else if (key_pos_reg == 5'd0)
                            phase_next = PH_EMPTYKEY;
                        else if (key_eq_reg && key_pos_reg == key_len)
                        begin
                            phase_next   = PH_COLON;
                            in_key_next  = 1'b0;
                            key_pos_next = 5'd0;
                        end
                        else
                        begin
                            in_key_next  = 1'b0;
                            key_pos_next = 5'd0;
                            key_eq_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (c == CH_COLON)
                            key_mode_next = !key_mode_reg;
                        else if (c == CH_COMMA && !key_mode_reg)
                            key_mode_next = 1'b1;
                        if (in_key_reg)
                        begin
                            if (!(32'(key_pos_reg) < MAX_KEY && key_pos_reg < key_len
                                  && c == tbyte))
                                key_eq_next = 1'b0;
                            if (32'(key_pos_reg) <= MAX_KEY)
                                key_pos_next = key_pos_reg + 5'd1;
                        end
                    end
                end
                PH_COLON:
                begin
                    if (c == CH_COLON)
                        phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (c != CH_SPACE && c != CH_COLON)
                    begin
                        key_pos_next = 5'd0;
                        inq_next     = 1'b0;
                        depth_next   = '0;
                        phase_next   = PH_VALUE;
                        if (c == CH_QUOTE)
                            kind_next = K_STRING;
                        else if (c == CH_LBRK || c == CH_LBRC)
                        begin
                            kind_next  = (c == CH_LBRK) ? K_ARRAY : K_OBJECT;
                            depth_next = DW'(1);
                            emit       = 1'b1;
                        end
                        else if (c == CH_N)
                        begin
                            kind_next = K_NULL;
                            emit      = 1'b1;
                        end
                        else if (c == CH_F || c == CH_T)
                        begin
                            kind_next = K_BOOLEAN;
                            emit      = 1'b1;
                        end
                        else
                        begin
                            kind_next = K_NUMBER;
                            do_val    = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                    do_val = 1'b1;
                default:
                    ;
            endcase
            if (do_val)
            begin
                if (c == CH_COLON || (c == CH_SPACE && (kind_next == K_STRING
                    || kind_next == K_ARRAY || kind_next == K_OBJECT)))
                    emit = 1'b1;
                else if (kind_next == K_STRING)
                begin
                    if (unesc_q)
                        phase_next = (key_pos_reg != 5'd0 && phase_reg == PH_VALUE)
                                     ? PH_FOUND : PH_BAD;
                    else
                        emit = 1'b1;
                end
                else if (kind_next == K_BOOLEAN || kind_next == K_NULL)
                begin
                    if (c == CH_SPACE || c == CH_COMMA)
                        phase_next = (key_pos_reg != 5'd0) ? PH_FOUND : PH_BAD;
                    else
                    begin
                        emit = 1'b1;
                        if (item.last)
                            phase_next = PH_FOUND;
                    end
                end
                else if (kind_next == K_NUMBER)
                begin
                    if (c == CH_DOT)
                        emit = 1'b1;
                    else if (c < CH_ZERO || c > CH_NINE)
                        phase_next = (key_pos_reg != 5'd0 && phase_reg == PH_VALUE)
                                     ? PH_FOUND : PH_BAD;
                    else
                    begin
                        emit = 1'b1;
                        if (item.last)
                            phase_next = PH_FOUND;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    if (unesc_q)
                        inq_next = !inq_reg;
                    if (!inq_next)
                    begin
                        if (c == opn && 32'(depth_reg) < MAX_DEPTH)
                            depth_next = depth_reg + DW'(1);
                        if (c == cls && depth_reg != '0)
                        begin
                            depth_next = depth_reg - DW'(1);
                            if (depth_reg == DW'(1))
                                phase_next = PH_FOUND;
                        end
                    end
                end
            end
            if (emit)
                key_pos_next = 5'd1;
        end
        if (item.short_doc)
            st = ST_SHORT;
        else if (phase_next == PH_KEYS)
            st = ST_NOTFOUND;
        else if (phase_next == PH_FOUND)
            st = ST_FOUND;
        else if (phase_next == PH_EMPTYKEY)
            st = ST_EMPTYKEY;
        else
            st = ST_BADVAL;
        res_valid      = step && (emit || item.last);
        res.out_byte   = emit ? c : 8'd0;
        res.byte_valid = emit;
        res.value_type = (emit || (item.last && st == ST_FOUND)) ? kind_next : 3'd0;
        res.done_res   = item.last;
        res.status     = item.last ? st : ST_FOUND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_KEYS;
            prev_reg     <= 8'd0;
            key_mode_reg <= 1'b1;
            in_key_reg   <= 1'b0;
            key_pos_reg  <= 5'd0;
            key_eq_reg   <= 1'b1;
            kind_reg     <= K_STRING;
            depth_reg    <= '0;
            inq_reg      <= 1'b0;
        end
        else if (step)
        begin
            if (item.last)
            begin
                phase_reg    <= PH_KEYS;
                prev_reg     <= 8'd0;
                key_mode_reg <= 1'b1;
                in_key_reg   <= 1'b0;
                key_pos_reg  <= 5'd0;
                key_eq_reg   <= 1'b1;
                kind_reg     <= K_STRING;
                depth_reg    <= '0;
                inq_reg      <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                if (item.cur_valid)
                    prev_reg <= c;
                key_mode_reg <= key_mode_next;
                in_key_reg   <= in_key_next;
                key_pos_reg  <= key_pos_next;
                key_eq_reg   <= key_eq_next;
                kind_reg     <= kind_next;
                depth_reg    <= depth_next;
                inq_reg      <= inq_next;
            end
        end
    end

    a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.last) |=> (phase_reg == PH_KEYS && key_pos_reg == 5'd0))
        else $error("state not cleared after done item");
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= MAX_DEPTH)
        else $error("nesting depth out of range");
    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |-> (phase_reg == PH_TYPE || phase_reg == PH_VALUE))
        else $error("value byte outside value phases");

endmodule

// ===== design/jkve_fifo.sv =====
// Two-entry result queue between the back part and the result ports.
// Depends on jkve_pkg.
module jkve_fifo
    import jkve_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  jkve_res_t wdata,
    input  logic      rd,
    output jkve_res_t rdata,
    output logic      full,
    output logic      empty
);

    jkve_res_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

// ===== design/json_key_value_extractor_top.sv =====
// Top level of the JSON key/value extractor: config registers, front,
// back and result queue. Depends on jkve_pkg and the jkve_* modules.
//
// channel  direction  handshake          payload
// input    in         push / full        in_byte, in_last
// result   out        pop / empty        out_byte, byte_valid, value_type,
//                                        done_res, status
// config   in         cfg_we             cfg_idx, cfg_data
//
// One item per cycle unless full; an item is processed when the next is accepted.
// The result queue holds two items; full rises only when both are waiting.
// Reset clears all control state and the target key registers.
// A stalled result side stops input once the queue is full.
module json_key_value_extractor_top
    import jkve_pkg::*;
#(
    parameter int MAX_KEY   = 16,
    parameter int MAX_DEPTH = 255
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic [2:0]  value_type,
    output logic        done_res,
    output logic [2:0]  status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [63:0] cfg_data
);

    logic [63:0] key_lo_reg, key_hi_reg;
    logic [4:0]  len_reg;
    jkve_item_t  item;
    jkve_res_t   res, head;
    logic        res_valid, take, q_full;

    assign take = push && !q_full;
    assign full = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= 64'd0;
            key_hi_reg <= 64'd0;
            len_reg    <= 5'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_KEY_LO: key_lo_reg <= cfg_data;
                REG_KEY_HI: key_hi_reg <= cfg_data;
                REG_LEN:    len_reg    <= cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    jkve_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .in_byte(in_byte), .in_last(in_last), .item(item)
    );

    jkve_back #(.MAX_KEY(MAX_KEY), .MAX_DEPTH(MAX_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .step(take), .item(item),
        .key_lo(key_lo_reg), .key_hi(key_hi_reg),
        .key_len((32'(len_reg) > MAX_KEY) ? 5'd0 : len_reg),
        .res_valid(res_valid), .res(res)
    );

    jkve_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(res_valid), .wdata(res),
        .rd(pop && !empty), .rdata(head), .full(q_full), .empty(empty)
    );

    assign out_byte   = head.out_byte;
    assign byte_valid = head.byte_valid;
    assign value_type = head.value_type;
    assign done_res   = head.done_res;
    assign status     = head.status;

endmodule
